// File: design/dscn_pkg.sv
// Shared types, constants and helpers for the DER subject common name extractor.
package dscn_pkg;

  localparam int unsigned MaxTagOctets    = 4;
  localparam int unsigned MaxLengthOctets = 4;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned NameLenW        = 11;
  localparam logic [NameLenW-1:0] NameLenReset = 11'd64;

  localparam logic [1:0] ST_NAME     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [4:0] TagMultiOctet = 5'h1F;
  localparam logic [4:0] TagSequence   = 5'd16;
  localparam logic [4:0] TagSet        = 5'd17;
  localparam logic [4:0] TagInteger    = 5'd2;
  localparam logic [4:0] TagOid        = 5'd6;
  localparam logic [4:0] TagUtf8      = 5'd12;
  localparam logic [4:0] TagPrintable = 5'd19;

  localparam logic [2:0] CfUnivPrim   = 3'd0;
  localparam logic [2:0] CfUnivCons   = 3'd1;
  localparam logic [2:0] CfCtxCons    = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] name_byte;
    logic       last_of_name;
  } result_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [7:0] cn_oid_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'd85;
      2'd1:    v = 8'd4;
      2'd2:    v = 8'd3;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/dscn_in_if.sv
// Input byte channel: valid/ready with certificate byte and end marker.
interface dscn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: design/dscn_out_if.sv
// Result channel: valid/ready with status, name byte and end-of-name flag.
interface dscn_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] name_byte;
  logic       last_of_name;

  modport source (output valid, output status, output name_byte, output last_of_name,
                  input ready);
  modport sink   (input valid, input status, input name_byte, input last_of_name,
                  output ready);
endinterface

// File: design/dscn_queue.sv
// Front end: accepts input transactions into a short queue ahead of the parser.
module dscn_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dscn_in_if.sink                      in_i,
  output dscn_pkg::item_t              item_o,
  output logic                         valid_o,
  input  logic                         pop_i,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  import dscn_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH+1);

  item_t              mem_q [DEPTH];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               push, pop;

  assign in_i.ready = (cnt_q != CntW'(DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != '0);
  assign valid_o    = (cnt_q != '0);
  assign item_o     = mem_q[rd_q];
  assign count_o    = cnt_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{in_byte: in_i.in_byte, last_byte: in_i.last_byte};
    end
  end

endmodule

// File: design/dscn_parser.sv
// Back end: TLV header decoder and certificate path walker with result register.
module dscn_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dscn_pkg::NameLenW-1:0] max_name_len_i,
  input  dscn_pkg::item_t               item_i,
  input  logic                          valid_i,
  output logic                          pop_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output dscn_pkg::result_t             res_o
);
  import dscn_pkg::*;

  typedef enum logic [3:0] {
    P_CERT, P_TBS, P_VER, P_SER, P_SIG, P_ISS, P_VAL, P_SUBJ,
    P_RDN, P_ATV, P_OID, P_VALUE, P_NAME, P_TOSET
  } phase_e;

  typedef enum logic [2:0] {
    HS_TAG, HS_TAGN, HS_LEN, HS_LENN, HS_BODY
  } hstep_e;

  phase_e      phase_q, phase_d;
  hstep_e      hs_q, hs_d;
  logic [31:0] tag_q, tag_d, len_q, len_d, off_q, off_d;
  logic [31:0] subj_end_q, subj_end_d, set_end_q, set_end_d, left_q, left_d;
  logic [2:0]  tag_oct_q, tag_oct_d, len_left_q, len_left_d, cf_q, cf_d;
  logic [1:0]  oid_q, oid_d;
  logic        iscn_q, iscn_d, fin_q, fin_d;
  logic        rv_q;
  result_t     res_q, res_d;
  logic        res_v;

  logic        pop;
  logic [7:0]  b;
  logic        hdr_done, go_rdn, go_setend, do_fail, cu, pu, match;
  logic [31:0] bl;
  logic [6:0]  n;

  assign pop         = valid_i && (!rv_q || res_ready_i);
  assign pop_o       = pop;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_comb begin
    phase_d    = phase_q;
    hs_d       = hs_q;
    tag_d      = tag_q;
    len_d      = len_q;
    off_d      = off_q;
    subj_end_d = subj_end_q;
    set_end_d  = set_end_q;
    left_d     = left_q;
    tag_oct_d  = tag_oct_q;
    len_left_d = len_left_q;
    cf_d       = cf_q;
    oid_d      = oid_q;
    iscn_d     = iscn_q;
    fin_d      = fin_q;
    res_v      = 1'b0;
    res_d      = '0;
    hdr_done   = 1'b0;
    go_rdn     = 1'b0;
    go_setend  = 1'b0;
    do_fail    = 1'b0;
    b          = item_i.in_byte;
    n          = b[6:0];
    bl         = left_q - 32'd1;
    cu         = 1'b0;
    pu         = 1'b0;
    match      = 1'b0;

    if (pop && !fin_q) begin
      off_d = sat_add(off_q, 32'd1);
      if (phase_q == P_TOSET) begin
        if (off_d >= set_end_q) go_rdn = 1'b1;
      end else begin
        case (hs_q)
          HS_TAG: begin
            cf_d = b[7:5];
            if (b[4:0] == TagMultiOctet) begin
              tag_d     = '0;
              tag_oct_d = '0;
              hs_d      = HS_TAGN;
            end else begin
              tag_d = {27'd0, b[4:0]};
              hs_d  = HS_LEN;
            end
          end
          HS_TAGN: begin
            tag_oct_d = tag_oct_q + 3'd1;
            if (tag_oct_d > 3'(MaxTagOctets)) begin
              do_fail = 1'b1;
            end else begin
              tag_d = {tag_q[24:0], b[6:0]};
              if (!b[7]) hs_d = HS_LEN;
            end
          end
          HS_LEN: begin
            if (b[7]) begin
              if (n == 7'd0 || n > 7'(MaxLengthOctets)) begin
                do_fail = 1'b1;
              end else begin
                len_d      = '0;
                len_left_d = n[2:0];
                hs_d       = HS_LENN;
              end
            end else begin
              len_d    = {24'd0, b};
              hdr_done = 1'b1;
            end
          end
          HS_LENN: begin
            len_d      = {len_q[23:0], b};
            len_left_d = len_left_q - 3'd1;
            if (len_left_d == '0) hdr_done = 1'b1;
          end
          HS_BODY: begin
            left_d = bl;
            if (phase_q == P_NAME) begin
              res_v = 1'b1;
              res_d = '{status: ST_NAME, name_byte: b, last_of_name: (bl == '0)};
              if (bl == '0) fin_d = 1'b1;
            end else begin
              if (phase_q == P_OID && iscn_q) begin
                if (b != cn_oid_byte(oid_q)) iscn_d = 1'b0;
                else oid_d = oid_q + 2'd1;
              end
              if (bl == '0) begin
                hs_d = HS_TAG;
                if (phase_q == P_VALUE) go_setend = 1'b1;
                else if (phase_q == P_OID) phase_d = P_VALUE;
                else if (phase_q >= P_VER && phase_q <= P_VAL)
                  phase_d = phase_e'(phase_q + 4'd1);
                else do_fail = 1'b1;
              end
            end
          end
          default: do_fail = 1'b1;
        endcase
      end

      if (hdr_done) begin
        hs_d = HS_TAG;
        cu   = (cf_d == CfUnivCons);
        pu   = (cf_d == CfUnivPrim);
        case (phase_q)
          P_CERT, P_TBS, P_ATV: begin
            if (!(cu && tag_d == 32'(TagSequence))) do_fail = 1'b1;
            else if (phase_q == P_ATV) phase_d = P_OID;
            else phase_d = phase_e'(phase_q + 4'd1);
          end
          P_VER, P_SER, P_SIG, P_ISS, P_VAL: begin
            if (phase_q == P_VER)
              match = (cf_d == CfCtxCons) && (tag_d == '0);
            else if (phase_q == P_SER)
              match = pu && (tag_d == 32'(TagInteger));
            else
              match = cu && (tag_d == 32'(TagSequence));
            if (!match) begin
              do_fail = 1'b1;
            end else if (len_d == '0) begin
              phase_d = phase_e'(phase_q + 4'd1);
            end else begin
              left_d = len_d;
              hs_d   = HS_BODY;
            end
          end
          P_SUBJ: begin
            if (!(cu && tag_d == 32'(TagSequence))) begin
              do_fail = 1'b1;
            end else begin
              subj_end_d = sat_add(off_d, len_d);
              go_rdn     = 1'b1;
            end
          end
          P_RDN: begin
            if (!(cu && tag_d == 32'(TagSet))) begin
              do_fail = 1'b1;
            end else begin
              set_end_d = sat_add(off_d, len_d);
              phase_d   = P_ATV;
            end
          end
          P_OID: begin
            if (!(pu && tag_d == 32'(TagOid))) begin
              do_fail = 1'b1;
            end else begin
              oid_d  = '0;
              iscn_d = (len_d == 32'd3);
              if (len_d == '0) begin
                phase_d = P_VALUE;
              end else begin
                left_d = len_d;
                hs_d   = HS_BODY;
              end
            end
          end
          P_VALUE: begin
            if (!pu) begin
              do_fail = 1'b1;
            end else if ((tag_d == 32'(TagUtf8) || tag_d == 32'(TagPrintable)) && iscn_q
                         && len_d <= {21'd0, max_name_len_i}) begin
              if (len_d == '0) begin
                res_v = 1'b1;
                res_d = '{status: ST_EMPTY, name_byte: 8'd0, last_of_name: 1'b0};
                fin_d = 1'b1;
              end else begin
                phase_d = P_NAME;
                left_d  = len_d;
                hs_d    = HS_BODY;
              end
            end else if (len_d == '0) begin
              go_setend = 1'b1;
            end else begin
              left_d = len_d;
              hs_d   = HS_BODY;
            end
          end
          default: do_fail = 1'b1;
        endcase
      end

      // walk back up to the next RDN set
      if (go_setend) begin
        if (off_d > set_end_d) do_fail = 1'b1;
        else if (off_d == set_end_d) go_rdn = 1'b1;
        else phase_d = P_TOSET;
      end
      if (go_rdn && !do_fail) begin
        if (off_d >= subj_end_d) begin
          res_v = 1'b1;
          res_d = '{status: ST_NOTFOUND, name_byte: 8'd0, last_of_name: 1'b0};
          fin_d = 1'b1;
        end else begin
          phase_d = P_RDN;
          hs_d    = HS_TAG;
        end
      end
      if (do_fail) begin
        res_v = 1'b1;
        res_d = '{status: ST_ERROR, name_byte: 8'd0, last_of_name: 1'b0};
        fin_d = 1'b1;
      end
      // truncated certificate
      if (item_i.last_byte && !fin_d) begin
        res_v = 1'b1;
        res_d = '{status: ST_ERROR, name_byte: 8'd0, last_of_name: 1'b0};
      end
    end

    // rearm on the final byte
    if (pop && item_i.last_byte) begin
      phase_d    = P_CERT;
      hs_d       = HS_TAG;
      tag_d      = '0;
      len_d      = '0;
      off_d      = '0;
      subj_end_d = '0;
      set_end_d  = '0;
      left_d     = '0;
      tag_oct_d  = '0;
      len_left_d = '0;
      cf_d       = '0;
      oid_d      = '0;
      iscn_d     = 1'b0;
      fin_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= P_CERT;
      hs_q       <= HS_TAG;
      tag_q      <= '0;
      len_q      <= '0;
      off_q      <= '0;
      subj_end_q <= '0;
      set_end_q  <= '0;
      left_q     <= '0;
      tag_oct_q  <= '0;
      len_left_q <= '0;
      cf_q       <= '0;
      oid_q      <= '0;
      iscn_q     <= 1'b0;
      fin_q      <= 1'b0;
      rv_q       <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hs_q       <= hs_d;
      tag_q      <= tag_d;
      len_q      <= len_d;
      off_q      <= off_d;
      subj_end_q <= subj_end_d;
      set_end_q  <= set_end_d;
      left_q     <= left_d;
      tag_oct_q  <= tag_oct_d;
      len_left_q <= len_left_d;
      cf_q       <= cf_d;
      oid_q      <= oid_d;
      iscn_q     <= iscn_d;
      fin_q      <= fin_d;
      if (pop && res_v) rv_q <= 1'b1;
      else if (res_ready_i) rv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res_v) res_q <= res_d;
  end

endmodule

// File: design/der_subject_common_name_extractor.sv
// Top level: input queue, DER parser and result register for the subject common name.
// A byte's result (if any) passes through two registers: the queue entry, then the parser's result register.
// Throughput: one byte per cycle unless a held result stalls the parser; the parser handles each byte in a single step.
// A held result stalls the parser; the input queue keeps taking bytes until it fills.
// Reset (rst_ni low, async) empties the queue, rearms the parser and sets max_name_len to 64.
// The parser also rearms itself after each byte marked last_byte.
module der_subject_common_name_extractor #(
  parameter int unsigned QUEUE_DEPTH = dscn_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dscn_pkg::NameLenW-1:0] cfg_data_i,
  dscn_in_if.sink                       in_i,
  dscn_out_if.source                    out_o
);
  import dscn_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH+1);

  logic [NameLenW-1:0] max_len_q;
  item_t               q_item;
  logic                q_valid, q_pop;
  logic [CntW-1:0]     q_count;
  result_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= NameLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  dscn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .item_o  (q_item),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .count_o (q_count)
  );

  dscn_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_name_len_i (max_len_q),
    .item_i         (q_item),
    .valid_i        (q_valid),
    .pop_o          (q_pop),
    .res_valid_o    (out_o.valid),
    .res_ready_i    (out_o.ready),
    .res_o          (res)
  );

  assign out_o.status       = res.status;
  assign out_o.name_byte    = res.name_byte;
  assign out_o.last_of_name = res.last_of_name;

  // only name transactions carry a character or an end-of-name mark
  a_res_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_NAME |-> out_o.name_byte == 8'd0 && !out_o.last_of_name)
    else $error("non-name result carries payload");

  a_queue_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && !(in_i.valid && in_i.ready) |=> q_count == $past(q_count) - 1'b1)
    else $error("queue count did not drop on pop");

  a_queue_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> q_valid)
    else $error("input stalled while queue empty");

endmodule

// File: sim/der_subject_common_name_extractor_tb.sv
// Testbench for the DER subject common name extractor: random and directed certificates.
module der_subject_common_name_extractor_tb;
  import dscn_pkg::*;

  typedef enum logic [3:0] {
    PH_CERT, PH_TBS, PH_VER, PH_SER, PH_SIG, PH_ISS, PH_VAL, PH_SUBJ,
    PH_RDN, PH_ATV, PH_OID, PH_VALUE, PH_NAME, PH_TOSET
  } parse_phase_e;

  typedef enum logic [2:0] {HD_TAG, HD_TAGN, HD_LEN, HD_LENN, HD_BODY} hdr_step_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [NameLenW-1:0] cfg_data_i = '0;

  dscn_in_if in_ch();
  dscn_out_if out_ch();

  der_subject_common_name_extractor dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [NameLenW-1:0] name_limit;
  parse_phase_e ph;
  hdr_step_e hs;
  logic [31:0] tag_acc, len_acc, offset, subj_end, rdn_end, remaining;
  logic [2:0] tag_cnt, len_left, cls_form;
  logic [1:0] oid_idx;
  logic cn_hit, done;
  logic got;
  result_t res;

  item_t pending_bytes[$];
  result_t expected_names[$];
  int unsigned errors = 0, n_results = 0, n_names = 0, n_certs = 0;
  bit no_idle = 0, hold_off = 0, sending_done = 0;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic clear_parser();
    ph = PH_CERT; hs = HD_TAG; tag_acc = 0; tag_cnt = 0; len_acc = 0; len_left = 0;
    cls_form = 0; offset = 0; subj_end = 0; rdn_end = 0; remaining = 0; oid_idx = 0;
    cn_hit = 0; done = 0;
  endtask

  task automatic give(logic [1:0] st, logic [7:0] b, logic l, bit fin);
    got = 1; res.status = st; res.name_byte = b; res.last_of_name = l;
    if (fin) done = 1;
  endtask

  task automatic enter_rdn();
    if (offset >= subj_end) give(ST_NOTFOUND, 0, 0, 1);
    else begin
      ph = PH_RDN; hs = HD_TAG;
    end
  endtask

  task automatic close_value();
    if (offset > rdn_end) give(ST_ERROR, 0, 0, 1);
    else if (offset == rdn_end) enter_rdn();
    else ph = PH_TOSET;
  endtask

  task automatic open_body(parse_phase_e nxt);
    if (len_acc == 0) begin
      ph = nxt; hs = HD_TAG;
    end else begin
      remaining = len_acc; hs = HD_BODY;
    end
  endtask

  task automatic finish_header();
    bit cons, prim;
    cons = cls_form == CfUnivCons;
    prim = cls_form == CfUnivPrim;
    hs = HD_TAG;
    case (ph)
      PH_CERT, PH_TBS, PH_ATV: begin
        if (!(cons && tag_acc == TagSequence)) give(ST_ERROR, 0, 0, 1);
        else ph = (ph == PH_ATV) ? PH_OID : parse_phase_e'(ph + 1);
      end
      PH_VER: begin
        if (!(cls_form == CfCtxCons && tag_acc == 0)) give(ST_ERROR, 0, 0, 1);
        else open_body(PH_SER);
      end
      PH_SER: begin
        if (!(prim && tag_acc == TagInteger)) give(ST_ERROR, 0, 0, 1);
        else open_body(PH_SIG);
      end
      PH_SIG, PH_ISS, PH_VAL: begin
        if (!(cons && tag_acc == TagSequence)) give(ST_ERROR, 0, 0, 1);
        else open_body(parse_phase_e'(ph + 1));
      end
      PH_SUBJ: begin
        if (!(cons && tag_acc == TagSequence)) give(ST_ERROR, 0, 0, 1);
        else begin
          subj_end = add_sat(offset, len_acc);
          enter_rdn();
        end
      end
      PH_RDN: begin
        if (!(cons && tag_acc == TagSet)) give(ST_ERROR, 0, 0, 1);
        else begin
          rdn_end = add_sat(offset, len_acc);
          ph = PH_ATV;
        end
      end
      PH_OID: begin
        if (!(prim && tag_acc == TagOid)) give(ST_ERROR, 0, 0, 1);
        else begin
          oid_idx = 0; cn_hit = (len_acc == 3); open_body(PH_VALUE);
        end
      end
      PH_VALUE: begin
        if (!prim) give(ST_ERROR, 0, 0, 1);
        else if ((tag_acc == TagUtf8 || tag_acc == TagPrintable) && cn_hit &&
                 len_acc <= {21'd0, name_limit}) begin
          if (len_acc == 0) give(ST_EMPTY, 0, 0, 1);
          else begin
            ph = PH_NAME; remaining = len_acc; hs = HD_BODY;
          end
        end else if (len_acc == 0) close_value();
        else begin
          remaining = len_acc; hs = HD_BODY;
        end
      end
      default: give(ST_ERROR, 0, 0, 1);
    endcase
  endtask

  task automatic eat_body(logic [7:0] b);
    logic [7:0] want;
    remaining = remaining - 1;
    if (ph == PH_NAME) begin
      give(ST_NAME, b, remaining == 0, remaining == 0);
      return;
    end
    if (ph == PH_OID && cn_hit) begin
      case (oid_idx)
        2'd0: want = 8'd85;
        2'd1: want = 8'd4;
        2'd2: want = 8'd3;
        default: want = 8'd0;
      endcase
      if (b != want) cn_hit = 0;
      else oid_idx = oid_idx + 1;
    end
    if (remaining != 0) return;
    hs = HD_TAG;
    if (ph == PH_VALUE) close_value();
    else if (ph == PH_OID) ph = PH_VALUE;
    else if (ph >= PH_VER && ph <= PH_VAL) ph = parse_phase_e'(ph + 1);
    else give(ST_ERROR, 0, 0, 1);
  endtask

  task automatic predict_byte(item_t it);
    logic [7:0] b;
    b = it.in_byte;
    if (done) begin
      if (it.last_byte) clear_parser();
      return;
    end
    got = 0; res = '0;
    offset = add_sat(offset, 1);
    if (ph == PH_TOSET) begin
      if (offset >= rdn_end) enter_rdn();
    end else begin
      case (hs)
        HD_TAG: begin
          cls_form = b[7:5];
          if (b[4:0] == TagMultiOctet) begin
            tag_acc = 0; tag_cnt = 0; hs = HD_TAGN;
          end else begin
            tag_acc = {27'd0, b[4:0]}; hs = HD_LEN;
          end
        end
        HD_TAGN: begin
          tag_cnt = tag_cnt + 1;
          if (tag_cnt > MaxTagOctets) give(ST_ERROR, 0, 0, 1);
          else begin
            tag_acc = {tag_acc[24:0], b[6:0]};
            if (!b[7]) hs = HD_LEN;
          end
        end
        HD_LEN: begin
          if (b[7]) begin
            if (b[6:0] < 1 || b[6:0] > MaxLengthOctets) give(ST_ERROR, 0, 0, 1);
            else begin
              len_acc = 0; len_left = b[2:0]; hs = HD_LENN;
            end
          end else begin
            len_acc = {24'd0, b}; finish_header();
          end
        end
        HD_LENN: begin
          len_acc = {len_acc[23:0], b};
          len_left = len_left - 1;
          if (len_left == 0) finish_header();
        end
        default: eat_body(b);
      endcase
    end
    if (it.last_byte) begin
      if (!done) give(ST_ERROR, 0, 0, 1);
      clear_parser();
    end
    if (got) expected_names.push_back(res);
  endtask

  // stimulus building
  typedef byte unsigned bytes_t[$];

  function automatic bytes_t tlv(byte unsigned tag, bytes_t body, bit longform = 0);
    bytes_t r;
    int n;
    n = body.size();
    r.push_back(tag);
    if (longform || n > 127) begin
      r.push_back(8'h82); r.push_back(n[15:8]); r.push_back(n[7:0]);
    end else r.push_back(n[7:0]);
    foreach (body[i]) r.push_back(body[i]);
    return r;
  endfunction

  function automatic bytes_t rand_bytes(int n);
    bytes_t r;
    repeat (n) r.push_back($urandom_range(0, 255));
    return r;
  endfunction

  function automatic bytes_t join_b(bytes_t a, bytes_t b);
    bytes_t r;
    r = a;
    foreach (b[i]) r.push_back(b[i]);
    return r;
  endfunction

  // rdn with given oid bytes, value tag and value
  function automatic bytes_t rdn(bytes_t oid, byte unsigned vtag, bytes_t val);
    return tlv(8'h31, tlv(8'h30, join_b(tlv(8'h06, oid), tlv(vtag, val))));
  endfunction

  function automatic bytes_t cert(bytes_t subj_body, bit lf);
    bytes_t t;
    t = tlv(8'hA0, tlv(8'h02, '{8'h02}));
    t = join_b(t, tlv(8'h02, rand_bytes($urandom_range(1, 4)), lf));
    t = join_b(t, tlv(8'h30, rand_bytes($urandom_range(0, 3))));
    t = join_b(t, tlv(8'h30, rand_bytes($urandom_range(0, 4))));
    t = join_b(t, tlv(8'h30, rand_bytes($urandom_range(0, 3))));
    t = join_b(t, tlv(8'h30, subj_body, lf));
    return tlv(8'h30, tlv(8'h30, t));
  endfunction

  function automatic bytes_t rand_cert();
    bytes_t s, c;
    int k;
    byte unsigned vt;
    repeat ($urandom_range(0, 3)) begin
      k = $urandom_range(0, 9);
      vt = ($urandom_range(0, 1)) ? 8'h0C : 8'h13;
      if (k == 0) vt = $urandom_range(0, 30);
      if (k < 5) s = join_b(s, rdn('{85, 4, 3}, vt, rand_bytes($urandom_range(0, 12))));
      else if (k < 8) s = join_b(s, rdn('{85, 4, $urandom_range(0, 10)}, vt,
                                        rand_bytes($urandom_range(0, 6))));
      else s = join_b(s, rdn(rand_bytes($urandom_range(1, 4)), vt, rand_bytes(3)));
    end
    c = cert(s, $urandom_range(0, 3) == 0);
    k = $urandom_range(0, 9);
    if (k == 0) c[$urandom_range(0, c.size() - 1)] = $urandom_range(0, 255);
    else if (k == 1 && c.size() > 2) c = c[0:$urandom_range(0, c.size() - 2)];
    else if (k == 2) c = join_b(c, rand_bytes($urandom_range(1, 4)));
    return c;
  endfunction

  task automatic queue_cert(bytes_t c);
    item_t it;
    foreach (c[i]) begin
      it.in_byte = c[i];
      it.last_byte = (i == c.size() - 1);
      pending_bytes.push_back(it);
    end
    n_certs++;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_names.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [NameLenW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    name_limit = v;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0; in_ch.in_byte <= '0; in_ch.last_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(pending_bytes.pop_front());
      end
      if ((in_ch.valid && !in_ch.ready) ) begin
        // hold the current transaction
      end else if (pending_bytes.size() != 0 && !hold_off &&
                   (no_idle || $urandom_range(0, 99) >= 17)) begin
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= pending_bytes[0].in_byte;
        in_ch.last_byte <= pending_bytes[0].last_byte;
      end else begin
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= $urandom_range(0, 255);
      end
    end
  end

  // the driver pops the head only on acceptance; keep pending_bytes[0] as the one on the bus

  // monitor
  int unsigned idle_cycles = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || $urandom_range(0, 99) >= 17;
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_names.size() == 0) begin
          $error("unexpected result status=%0d", out_ch.status);
          errors++;
        end else begin
          want = expected_names.pop_front();
          if (want.status == ST_NAME) n_names++;
          if (out_ch.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_ch.status); errors++;
          end
          if (out_ch.name_byte !== want.name_byte) begin
            $error("name_byte expected %0h got %0h", want.name_byte, out_ch.name_byte);
            errors++;
          end
          if (out_ch.last_of_name !== want.last_of_name) begin
            $error("last_of_name expected %0d got %0d", want.last_of_name,
                   out_ch.last_of_name);
            errors++;
          end
        end
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    bytes_t s;
    int total;
    clear_parser();
    name_limit = NameLenReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: found, empty, printable, not found, long-tag error, indefinite and overlong length
    queue_cert(cert(rdn('{85, 4, 3}, 8'h0C, '{8'h00, 8'hFF, 8'h41}), 0));
    queue_cert(cert(rdn('{85, 4, 3}, 8'h13, '{}), 1));
    queue_cert(cert(join_b(rdn('{85, 4, 6}, 8'h13, '{8'h55}),
                           rdn('{85, 4, 3}, 8'h13, '{8'h5A})), 0));
    queue_cert(cert('{}, 0));
    queue_cert(cert(rdn('{85, 4, 7}, 8'h0C, '{8'h01}), 0));
    queue_cert('{8'h3F, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h00});
    queue_cert('{8'h30, 8'h80, 8'h00});
    queue_cert('{8'h30, 8'h85, 8'h00});
    queue_cert('{8'h30, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h30, 8'h00, 8'h01});
    queue_cert(cert(rdn('{85, 4, 3}, 8'h04, '{8'h61}), 0));
    wait_drained();
    set_limit(11'd0);
    queue_cert(cert(rdn('{85, 4, 3}, 8'h0C, '{8'h61}), 0));
    queue_cert(cert(rdn('{85, 4, 3}, 8'h0C, '{}), 0));
    wait_drained();
    set_limit(11'd2047);
    s = rdn('{85, 4, 3}, 8'h0C, rand_bytes(300));
    queue_cert(cert(s, 0));
    wait_drained();
    total = 0;
    for (int ph_i = 0; ph_i < 4; ph_i++) begin
      case (ph_i)
        0: set_limit(11'd5);
        1: set_limit(11'd1024);
        2: set_limit(11'd64);
        default: set_limit($urandom_range(0, 12));
      endcase
      no_idle = (ph_i == 1);
      while (total < (ph_i + 1) * 160) begin
        s = rand_cert();
        total += s.size() > 0 ? s.size() : 0;
        if (s.size() != 0) queue_cert(s);
        if (ph_i == 2 && total % 7 == 0) begin
          hold_off = 1;
          while (expected_names.size() != 0 || in_ch.valid) @(posedge clk_i);
          hold_off = 0;
        end
      end
      wait_drained();
    end
    repeat (20) @(posedge clk_i);
    $display("covered %0d certificates, %0d results, %0d name bytes", n_certs, n_results,
             n_names);
    $display("max_name_len settings 64, 0, 2047, 5, 1024, small random");
    if (errors == 0 && expected_names.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: der_subject_common_name_extractor.f
design/dscn_pkg.sv
design/dscn_in_if.sv
design/dscn_out_if.sv
design/dscn_queue.sv
design/dscn_parser.sv
design/der_subject_common_name_extractor.sv
sim/der_subject_common_name_extractor_tb.sv
